// ===== rtl/rgip_pkg.sv =====
`timescale 1ns / 1ps
package rgip_pkg;

   localparam int NUM_TERMS = 20;
   localparam int ADDR_W = 8;
   localparam int TERM_W = 5;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [TERM_W-1:0] term_type;
   typedef logic signed [63:0] word_type;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_DIRECT  = 2'd1,
      OP_INVERSE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_NRD_OFF, ST_NRD_SC, ST_NCHK, ST_NDIV,
      ST_MONO_A, ST_MONO_B, ST_MONO_W,
      ST_DOT_RD, ST_DOT_MUL, ST_DOT_W, ST_DCHK,
      ST_RDIV, ST_DEN_M, ST_DEN_W, ST_DEN_ADD, ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   localparam term_type TERM_FIRST_PRODUCT = 5'd4;
   localparam term_type TERM_LAST = TERM_W'(NUM_TERMS - 1);

   localparam addr_type W_LAT_OFF = ADDR_W'(8 * NUM_TERMS + 0);
   localparam addr_type W_LON_OFF = ADDR_W'(8 * NUM_TERMS + 2);
   localparam addr_type W_HGT_OFF = ADDR_W'(8 * NUM_TERMS + 4);
   localparam addr_type W_LIN_OFF = ADDR_W'(8 * NUM_TERMS + 6);
   localparam addr_type W_SMP_OFF = ADDR_W'(8 * NUM_TERMS + 8);

   localparam word_type WORD_MIN = {1'b1, {63{1'b0}}};
   localparam word_type WORD_MAX = {1'b0, {63{1'b1}}};

   function automatic logic [63:0] mag(input word_type a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   function automatic word_type sat_mag(input logic neg, input logic over,
                                        input logic [63:0] m);
      if (neg) begin
         if (over || m[63]) return WORD_MIN;
         return word_type'(~m + 64'd1);
      end
      if (over || m[63]) return WORD_MAX;
      return word_type'(m);
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? WORD_MIN : WORD_MAX;
      return word_type'(s[63:0]);
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? WORD_MIN : WORD_MAX;
      return word_type'(s[63:0]);
   endfunction

   function automatic addr_type norm_off(input logic direct, input logic [1:0] k);
      unique case (k)
         2'd0: return direct ? W_SMP_OFF : W_LON_OFF;
         2'd1: return direct ? W_LIN_OFF : W_LAT_OFF;
         default: return W_HGT_OFF;
      endcase
   endfunction

   function automatic addr_type den_off(input logic direct, input logic p);
      if (!p) return direct ? W_LAT_OFF : W_SMP_OFF;
      return direct ? W_LON_OFF : W_LIN_OFF;
   endfunction

   // Accumulator order: first numerator, first denominator, second numerator,
   // second denominator.
   function automatic addr_type block_base(input logic direct, input logic [1:0] b);
      if (direct) return ADDR_W'(NUM_TERMS * int'(b));
      unique case (b)
         2'd0: return ADDR_W'(6 * NUM_TERMS);
         2'd1: return ADDR_W'(7 * NUM_TERMS);
         2'd2: return ADDR_W'(4 * NUM_TERMS);
         default: return ADDR_W'(5 * NUM_TERMS);
      endcase
   endfunction

   function automatic term_type mono_opa(input term_type j);
      unique case (j)
         5'd4, 5'd5, 5'd7: return 5'd1;
         5'd6, 5'd8: return 5'd2;
         5'd9: return 5'd3;
         5'd10: return 5'd4;
         5'd11, 5'd14, 5'd17: return 5'd7;
         5'd12, 5'd15, 5'd18: return 5'd8;
         5'd13, 5'd16, 5'd19: return 5'd9;
         default: return 5'd0;
      endcase
   endfunction

   function automatic term_type mono_opb(input term_type j);
      unique case (j)
         5'd7, 5'd11, 5'd12, 5'd13: return 5'd1;
         5'd4, 5'd8, 5'd14, 5'd15, 5'd16: return 5'd2;
         5'd5, 5'd6, 5'd9, 5'd10, 5'd17, 5'd18, 5'd19: return 5'd3;
         default: return 5'd0;
      endcase
   endfunction

endpackage

// ===== rtl/rgip_if.sv =====
`timescale 1ns / 1ps
interface rgip_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  table_index;
   logic signed [63:0] table_value;
   logic signed [63:0] coord_a;
   logic signed [63:0] coord_b;
   logic signed [63:0] coord_c;

   modport source (output valid, operation, table_index, table_value,
                   coord_a, coord_b, coord_c, input ready);
   modport sink (input valid, operation, table_index, table_value,
                 coord_a, coord_b, coord_c, output ready);
endinterface

interface rgip_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [63:0] result_a;
   logic signed [63:0] result_b;
   logic signed [63:0] result_c;
   logic        status;

   modport source (output valid, result_a, result_b, result_c, status,
                   input ready);
   modport sink (input valid, result_a, result_b, result_c, status,
                 output ready);
endinterface

// ===== rtl/rpc_ground_image_projection_core.sv =====
`timescale 1ns / 1ps
// Rational polynomial camera projection engine.
// Items arrive on req_bus and results leave on rsp_bus; each is a
// valid/ready transfer. A load item (operation 0) writes one word of the
// coefficient memory and gives no result; an index beyond the table and
// operation 3 are dropped. An image-to-ground (1) or ground-to-image (2)
// item gives exactly one result. Without an error, three normalizing
// divisions, 98 products and two ratio divisions run one after the other.
// Each product runs in the shared multiplier (four 32 by 32 partial
// products) and each division in the bit-serial divider. A zero scale or
// denominator ends the item early with the error result. One item is
// worked on at a time; req_bus is ready only while the engine is idle, so
// no new item is taken before the last projection is finished.
// The result waits in an output register, so the next item may be taken
// while rsp_bus is stalled; a finished result waits in the engine until
// the register is free. Reset empties the output register and returns the
// engine to idle. The coefficient memory is not cleared: every word used
// by a projection must be loaded first.
module rpc_ground_image_projection_core #(
   parameter int FRAC_BITS = 32,
   parameter int TABLE_WORDS = 170
) (
   input logic clock,
   input logic reset,
   rgip_req_if.sink   req_bus,
   rgip_rsp_if.source rsp_bus
);
   localparam int AW = $clog2(TABLE_WORDS);

   rgip_pkg::state_type state_ff, state_in;

   logic              dir_ff;
   logic [1:0]        k_ff;
   rgip_pkg::term_type term_ff;
   logic [1:0]        blk_ff;
   logic              p_ff;
   logic              err_ff;
   rgip_pkg::word_type coord_a_ff, coord_b_ff, coord_c_ff;
   rgip_pkg::word_type diff_ff, opa_ff, ratio_ff, prod_ff;
   rgip_pkg::word_type acc_ff [4];
   rgip_pkg::word_type res_ff [2];
   rgip_pkg::word_type mono_ff [rgip_pkg::NUM_TERMS];

   logic              rsp_valid_ff;
   rgip_pkg::word_type rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic              rsp_status_ff;

   logic              req_fire, out_free, load_wr;
   rgip_pkg::addr_type rd_addr;
   logic [63:0]       rd_data;
   rgip_pkg::term_type mono_raddr;
   rgip_pkg::word_type mono_rd, coord_sel;
   logic              mul_start, div_start;
   rgip_pkg::word_type mul_a, mul_b, div_n, div_d, mul_p, div_q;
   rgip_pkg::unit_sts_type mul_sts, div_sts;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign load_wr = req_fire && (req_bus.operation == rgip_pkg::OP_LOAD)
                    && ({1'b0, req_bus.table_index} < 9'(TABLE_WORDS));
   assign mono_rd = mono_ff[mono_raddr];

   always_comb begin
      unique case (k_ff)
         2'd0: coord_sel = dir_ff ? coord_a_ff : coord_b_ff;
         2'd1: coord_sel = dir_ff ? coord_b_ff : coord_a_ff;
         default: coord_sel = coord_c_ff;
      endcase
   end

   rgip_mem #(.TABLE_WORDS(TABLE_WORDS)) u_mem (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_bus.table_index[AW-1:0]),
      .wr_data (req_bus.table_value),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (rd_data)
   );

   rgip_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .sts (mul_sts), .prod (mul_p)
   );

   rgip_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .n (div_n), .d (div_d), .sts (div_sts), .quo (div_q)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rgip_pkg::ST_IDLE:
            if (req_fire && (req_bus.operation == rgip_pkg::OP_DIRECT ||
                             req_bus.operation == rgip_pkg::OP_INVERSE)) begin
               state_in = rgip_pkg::ST_NRD_OFF;
            end
         rgip_pkg::ST_NRD_OFF: state_in = rgip_pkg::ST_NRD_SC;
         rgip_pkg::ST_NRD_SC:  state_in = rgip_pkg::ST_NCHK;
         rgip_pkg::ST_NCHK:
            state_in = (rd_data == '0) ? rgip_pkg::ST_DONE : rgip_pkg::ST_NDIV;
         rgip_pkg::ST_NDIV:
            if (div_sts.done) begin
               state_in = (k_ff == 2'd2) ? rgip_pkg::ST_MONO_A : rgip_pkg::ST_NRD_OFF;
            end
         rgip_pkg::ST_MONO_A: state_in = rgip_pkg::ST_MONO_B;
         rgip_pkg::ST_MONO_B: state_in = rgip_pkg::ST_MONO_W;
         rgip_pkg::ST_MONO_W:
            if (mul_sts.done) begin
               state_in = (term_ff == rgip_pkg::TERM_LAST) ? rgip_pkg::ST_DOT_RD
                                                           : rgip_pkg::ST_MONO_A;
            end
         rgip_pkg::ST_DOT_RD:  state_in = rgip_pkg::ST_DOT_MUL;
         rgip_pkg::ST_DOT_MUL: state_in = rgip_pkg::ST_DOT_W;
         rgip_pkg::ST_DOT_W:
            if (mul_sts.done) begin
               state_in = (term_ff == rgip_pkg::TERM_LAST && blk_ff == 2'd3)
                          ? rgip_pkg::ST_DCHK : rgip_pkg::ST_DOT_RD;
            end
         rgip_pkg::ST_DCHK:
            state_in = (acc_ff[1] == '0 || acc_ff[3] == '0) ? rgip_pkg::ST_DONE
                                                              : rgip_pkg::ST_RDIV;
         rgip_pkg::ST_RDIV:
            if (div_sts.done) begin
               state_in = rgip_pkg::ST_DEN_M;
            end
         rgip_pkg::ST_DEN_M: state_in = rgip_pkg::ST_DEN_W;
         rgip_pkg::ST_DEN_W:
            if (mul_sts.done) begin
               state_in = rgip_pkg::ST_DEN_ADD;
            end
         rgip_pkg::ST_DEN_ADD:
            state_in = p_ff ? rgip_pkg::ST_DONE : rgip_pkg::ST_RDIV;
         rgip_pkg::ST_DONE:
            if (out_free) begin
               state_in = rgip_pkg::ST_IDLE;
            end
         default: state_in = rgip_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      rd_addr = rgip_pkg::block_base(dir_ff, blk_ff) + rgip_pkg::ADDR_W'(term_ff);
      mono_raddr = term_ff;
      mul_start = 1'b0;
      mul_a = mono_rd;
      mul_b = rd_data;
      div_start = 1'b0;
      div_n = diff_ff;
      div_d = rd_data;
      unique case (state_ff)
         rgip_pkg::ST_IDLE: req_bus.ready = 1'b1;
         rgip_pkg::ST_NRD_OFF: rd_addr = rgip_pkg::norm_off(dir_ff, k_ff);
         rgip_pkg::ST_NRD_SC: rd_addr = rgip_pkg::norm_off(dir_ff, k_ff) + 8'd1;
         rgip_pkg::ST_NCHK: div_start = (rd_data != '0);
         rgip_pkg::ST_MONO_A: mono_raddr = rgip_pkg::mono_opa(term_ff);
         rgip_pkg::ST_MONO_B: begin
            mono_raddr = rgip_pkg::mono_opb(term_ff);
            mul_start = 1'b1;
            mul_a = opa_ff;
            mul_b = mono_rd;
         end
         rgip_pkg::ST_DOT_MUL: mul_start = 1'b1;
         rgip_pkg::ST_DCHK: begin
            div_start = (acc_ff[1] != '0 && acc_ff[3] != '0);
            div_n = acc_ff[0];
            div_d = acc_ff[1];
         end
         rgip_pkg::ST_RDIV: rd_addr = rgip_pkg::den_off(dir_ff, p_ff) + 8'd1;
         rgip_pkg::ST_DEN_M: begin
            mul_start = 1'b1;
            mul_a = ratio_ff;
         end
         rgip_pkg::ST_DEN_W: rd_addr = rgip_pkg::den_off(dir_ff, p_ff);
         rgip_pkg::ST_DEN_ADD: begin
            div_start = !p_ff;
            div_n = acc_ff[2];
            div_d = acc_ff[3];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rgip_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         rgip_pkg::ST_IDLE:
            if (req_fire) begin
               dir_ff <= req_bus.operation == rgip_pkg::OP_DIRECT;
               coord_a_ff <= req_bus.coord_a;
               coord_b_ff <= req_bus.coord_b;
               coord_c_ff <= req_bus.coord_c;
               k_ff <= '0;
               err_ff <= 1'b0;
               mono_ff[0] <= rgip_pkg::word_type'(64'd1 << FRAC_BITS);
            end
         rgip_pkg::ST_NRD_SC: diff_ff <= rgip_pkg::sat_sub(coord_sel, rd_data);
         rgip_pkg::ST_NCHK:
            if (rd_data == '0) begin
               err_ff <= 1'b1;
            end
         rgip_pkg::ST_NDIV:
            if (div_sts.done) begin
               mono_ff[rgip_pkg::TERM_W'(k_ff) + 5'd1] <= div_q;
               k_ff <= k_ff + 2'd1;
               term_ff <= rgip_pkg::TERM_FIRST_PRODUCT;
            end
         rgip_pkg::ST_MONO_A: opa_ff <= mono_rd;
         rgip_pkg::ST_MONO_W:
            if (mul_sts.done) begin
               mono_ff[term_ff] <= mul_p;
               if (term_ff == rgip_pkg::TERM_LAST) begin
                  term_ff <= '0;
                  blk_ff <= '0;
                  for (int i = 0; i < 4; i++) acc_ff[i] <= '0;
               end else begin
                  term_ff <= term_ff + 5'd1;
               end
            end
         rgip_pkg::ST_DOT_W:
            if (mul_sts.done) begin
               acc_ff[blk_ff] <= rgip_pkg::sat_add(acc_ff[blk_ff], mul_p);
               blk_ff <= blk_ff + 2'd1;
               if (blk_ff == 2'd3) begin
                  term_ff <= term_ff + 5'd1;
               end
            end
         rgip_pkg::ST_DCHK: begin
            p_ff <= 1'b0;
            if (acc_ff[1] == '0 || acc_ff[3] == '0) begin
               err_ff <= 1'b1;
            end
         end
         rgip_pkg::ST_RDIV:
            if (div_sts.done) begin
               ratio_ff <= div_q;
            end
         rgip_pkg::ST_DEN_W:
            if (mul_sts.done) begin
               prod_ff <= mul_p;
            end
         rgip_pkg::ST_DEN_ADD: begin
            res_ff[p_ff] <= rgip_pkg::sat_add(prod_ff, rd_data);
            p_ff <= 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == rgip_pkg::ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == rgip_pkg::ST_DONE && out_free) begin
         rsp_a_ff <= err_ff ? '0 : res_ff[0];
         rsp_b_ff <= err_ff ? '0 : res_ff[1];
         rsp_c_ff <= err_ff ? '0 : (dir_ff ? coord_c_ff : mono_ff[3]);
         rsp_status_ff <= err_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.result_a = rsp_a_ff;
   assign rsp_bus.result_b = rsp_b_ff;
   assign rsp_bus.result_c = rsp_c_ff;
   assign rsp_bus.status = rsp_status_ff;

`ifndef ASSERT_OFF
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == rgip_pkg::ST_MONO_W ||
                        state_ff == rgip_pkg::ST_DOT_W ||
                        state_ff == rgip_pkg::ST_DEN_W))
      else $error("multiplier finished outside a waiting state");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == rgip_pkg::ST_NDIV ||
                        state_ff == rgip_pkg::ST_RDIV))
      else $error("divider finished outside a waiting state");
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_sts.busy)
      else $error("multiplier started while busy");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_sts.busy)
      else $error("divider started while busy");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |->
         (rsp_a_ff == '0 && rsp_b_ff == '0 && rsp_c_ff == '0))
      else $error("error result carries non-zero data");
`endif
endmodule

// ===== rtl/rgip_mem.sv =====
`timescale 1ns / 1ps
module rgip_mem #(
   parameter int TABLE_WORDS = 170
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(TABLE_WORDS)-1:0] wr_addr,
   input  logic [63:0] wr_data,
   input  logic [$clog2(TABLE_WORDS)-1:0] rd_addr,
   output logic [63:0] rd_data
);
   logic [63:0] mem_ff [TABLE_WORDS];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/rgip_mul.sv =====
`timescale 1ns / 1ps
module rgip_mul #(
   parameter int FRAC_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  rgip_pkg::word_type a,
   input  rgip_pkg::word_type b,
   output rgip_pkg::unit_sts_type sts,
   output rgip_pkg::word_type prod
);
   localparam logic [2:0] MUL_STEPS = 3'd4;

   logic         busy_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  x_ff, y_ff;
   logic         neg_ff;
   logic [127:0] acc_ff;
   logic [31:0]  xs, ys;
   logic [63:0]  pp;
   logic [1:0]   sh;
   logic [127:0] shifted;

   assign xs = cnt_ff[0] ? x_ff[63:32] : x_ff[31:0];
   assign ys = cnt_ff[1] ? y_ff[63:32] : y_ff[31:0];
   assign pp = {32'd0, xs} * {32'd0, ys};
   assign sh = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
   assign shifted = {64'd0, pp} << {sh, 5'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == MUL_STEPS) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= rgip_pkg::mag(a);
         y_ff <= rgip_pkg::mag(b);
         neg_ff <= a[63] ^ b[63];
         acc_ff <= '0;
      end else if (busy_ff && cnt_ff != MUL_STEPS) begin
         acc_ff <= acc_ff + shifted;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = busy_ff && (cnt_ff == MUL_STEPS);
   assign prod = rgip_pkg::sat_mag(neg_ff, |acc_ff[127:FRAC_BITS+64],
                                   acc_ff[FRAC_BITS+63:FRAC_BITS]);
endmodule

// ===== rtl/rgip_div.sv =====
`timescale 1ns / 1ps
module rgip_div #(
   parameter int FRAC_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  rgip_pkg::word_type n,
   input  rgip_pkg::word_type d,
   output rgip_pkg::unit_sts_type sts,
   output rgip_pkg::word_type quo
);
   localparam logic [6:0] DIV_STEPS = 7'd64;

   logic         busy_ff;
   logic [6:0]   cnt_ff;
   logic [63:0]  r_ff, lo_ff, y_ff, q_ff;
   logic         neg_ff, over_ff;
   logic [63:0]  x;
   logic [127:0] wide;
   logic [64:0]  t, t_sub;
   logic         ge;

   assign x = rgip_pkg::mag(n);
   assign wide = {64'd0, x} << FRAC_BITS;
   assign t = {r_ff, lo_ff[63]};
   assign t_sub = t - {1'b0, y_ff};
   assign ge = t >= {1'b0, y_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == DIV_STEPS) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         y_ff <= rgip_pkg::mag(d);
         r_ff <= wide[127:64];
         lo_ff <= wide[63:0];
         over_ff <= wide[127:64] >= rgip_pkg::mag(d);
         neg_ff <= n[63] ^ d[63];
         q_ff <= '0;
      end else if (busy_ff && cnt_ff != DIV_STEPS) begin
         r_ff <= ge ? t_sub[63:0] : t[63:0];
         lo_ff <= {lo_ff[62:0], 1'b0};
         q_ff <= {q_ff[62:0], ge};
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = busy_ff && (cnt_ff == DIV_STEPS);
   assign quo = rgip_pkg::sat_mag(neg_ff, over_ff, q_ff);
endmodule

// ===== tb/tb_rpc_ground_image_projection_core.sv =====
`timescale 1ns / 1ps
module tb_rpc_ground_image_projection_core;

   localparam int MEM_WORDS = 170;
   localparam int FRAC = 32;
   localparam int LAT_OFF = 160, LAT_SC = 161, LON_OFF = 162, LON_SC = 163;
   localparam int HGT_OFF = 164, HGT_SC = 165, LIN_OFF = 166, LIN_SC = 167;
   localparam int SMP_OFF = 168, SMP_SC = 169;
   localparam rgip_pkg::word_type ONE = 64'sd1 <<< FRAC;
   localparam int RANDOM_ITEMS = 1350;

   typedef struct {
      rgip_pkg::op_type op;
      logic [7:0] idx;
      rgip_pkg::word_type val, a, b, c;
   } point_cmd_type;

   typedef struct {
      rgip_pkg::word_type a, b, c;
      logic status;
   } point_res_type;

   typedef struct {
      point_cmd_type cmd;
      logic typed;
      point_res_type res;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   rgip_req_if req_bus ();
   rgip_rsp_if rsp_bus ();

   rpc_ground_image_projection_core DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   always #5 clock = ~clock;

   rgip_pkg::word_type coef_mem [MEM_WORDS];
   point_res_type pending_q [$];
   int errors = 0;
   int accepted = 0;
   bit quiet = 1'b0;
   bit hold_off = 1'b0;

   function automatic logic [63:0] magn(input rgip_pkg::word_type x);
      return x[63] ? (~x + 64'd1) : x;
   endfunction

   function automatic rgip_pkg::word_type clamp(input logic neg, input logic over,
                                                input logic [63:0] m);
      if (neg) begin
         return (over || m[63]) ? rgip_pkg::WORD_MIN : rgip_pkg::word_type'(~m + 64'd1);
      end
      return (over || m[63]) ? rgip_pkg::WORD_MAX : rgip_pkg::word_type'(m);
   endfunction

   function automatic rgip_pkg::word_type q_add(input rgip_pkg::word_type x,
                                                input rgip_pkg::word_type y);
      logic signed [64:0] s;
      s = 65'(x) + 65'(y);
      if (s > 65'(rgip_pkg::WORD_MAX)) return rgip_pkg::WORD_MAX;
      if (s < 65'(rgip_pkg::WORD_MIN)) return rgip_pkg::WORD_MIN;
      return rgip_pkg::word_type'(s[63:0]);
   endfunction

   function automatic rgip_pkg::word_type q_sub(input rgip_pkg::word_type x,
                                                input rgip_pkg::word_type y);
      logic signed [64:0] s;
      s = 65'(x) - 65'(y);
      if (s > 65'(rgip_pkg::WORD_MAX)) return rgip_pkg::WORD_MAX;
      if (s < 65'(rgip_pkg::WORD_MIN)) return rgip_pkg::WORD_MIN;
      return rgip_pkg::word_type'(s[63:0]);
   endfunction

   function automatic rgip_pkg::word_type q_mul(input rgip_pkg::word_type x,
                                                input rgip_pkg::word_type y);
      logic [127:0] p;
      p = {64'd0, magn(x)} * {64'd0, magn(y)};
      return clamp(x[63] ^ y[63], |p[127:64+FRAC], p[63+FRAC:FRAC]);
   endfunction

   function automatic rgip_pkg::word_type q_div(input rgip_pkg::word_type n,
                                                input rgip_pkg::word_type d);
      logic [127:0] quo;
      quo = ({64'd0, magn(n)} << FRAC) / {64'd0, magn(d)};
      return clamp(n[63] ^ d[63], |quo[127:64], quo[63:0]);
   endfunction

   function automatic rgip_pkg::word_type poly_sum(input rgip_pkg::word_type t [20],
                                                   input int base);
      rgip_pkg::word_type acc;
      acc = 0;
      for (int i = 0; i < 20; i++) acc = q_add(acc, q_mul(t[i], coef_mem[base + i]));
      return acc;
   endfunction

   function automatic point_res_type project_point(input logic direct,
                                                   input rgip_pkg::word_type a,
                                                   input rgip_pkg::word_type b,
                                                   input rgip_pkg::word_type c);
      point_res_type r;
      rgip_pkg::word_type u, v, w, uv, uu, vv, ww, n1, d1, n2, d2;
      rgip_pkg::word_type t [20];
      int us, uo, vs, vo, b1, b2, s1, o1, s2, o2;
      r = '{0, 0, 0, 1'b1};
      us = direct ? SMP_SC : LON_SC;  uo = direct ? SMP_OFF : LON_OFF;
      vs = direct ? LIN_SC : LAT_SC;  vo = direct ? LIN_OFF : LAT_OFF;
      b1 = direct ? 0 : 120;          b2 = direct ? 40 : 80;
      s1 = direct ? LAT_SC : SMP_SC;  o1 = direct ? LAT_OFF : SMP_OFF;
      s2 = direct ? LON_SC : LIN_SC;  o2 = direct ? LON_OFF : LIN_OFF;
      if (coef_mem[us] == 0 || coef_mem[vs] == 0 || coef_mem[HGT_SC] == 0) return r;
      u = q_div(q_sub(direct ? a : b, coef_mem[uo]), coef_mem[us]);
      v = q_div(q_sub(direct ? b : a, coef_mem[vo]), coef_mem[vs]);
      w = q_div(q_sub(c, coef_mem[HGT_OFF]), coef_mem[HGT_SC]);
      uv = q_mul(u, v); uu = q_mul(u, u); vv = q_mul(v, v); ww = q_mul(w, w);
      t = '{ONE, u, v, w, uv, q_mul(u, w), q_mul(v, w), uu, vv, ww,
            q_mul(uv, w), q_mul(uu, u), q_mul(vv, u), q_mul(ww, u), q_mul(uu, v),
            q_mul(vv, v), q_mul(ww, v), q_mul(uu, w), q_mul(vv, w), q_mul(ww, w)};
      n1 = poly_sum(t, b1); d1 = poly_sum(t, b1 + 20);
      n2 = poly_sum(t, b2); d2 = poly_sum(t, b2 + 20);
      if (d1 == 0 || d2 == 0) return r;
      r.a = q_add(q_mul(q_div(n1, d1), coef_mem[s1]), coef_mem[o1]);
      r.b = q_add(q_mul(q_div(n2, d2), coef_mem[s2]), coef_mem[o2]);
      r.c = direct ? c : w;
      r.status = 1'b0;
      return r;
   endfunction

   task automatic send_cmd(input point_cmd_type cmd, input logic typed,
                           input point_res_type res);
      int gap;
      point_res_type want;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= cmd.op;
      req_bus.table_index <= cmd.idx;
      req_bus.table_value <= cmd.val;
      req_bus.coord_a <= cmd.a;
      req_bus.coord_b <= cmd.b;
      req_bus.coord_c <= cmd.c;
      do @(posedge clock); while (!req_bus.ready);
      accepted++;
      if (cmd.op == rgip_pkg::OP_LOAD) begin
         if (cmd.idx < MEM_WORDS) coef_mem[cmd.idx] = cmd.val;
      end else if (cmd.op != rgip_pkg::OP_NONE) begin
         if (typed) begin
            want = res;
         end else begin
            want = project_point(cmd.op == rgip_pkg::OP_DIRECT, cmd.a, cmd.b, cmd.c);
         end
         pending_q.insert(pending_q.size(), want);
      end
   endtask

   function automatic point_cmd_type mk(input rgip_pkg::op_type op, input int idx,
                                        input rgip_pkg::word_type val,
                                        input rgip_pkg::word_type a,
                                        input rgip_pkg::word_type b,
                                        input rgip_pkg::word_type c);
      point_cmd_type k;
      k = '{op, 8'(idx), val, a, b, c};
      return k;
   endfunction

   function automatic rgip_pkg::word_type rand_word();
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: return 0;
         2: return ONE;
         3: return rgip_pkg::word_type'($signed({$urandom, $urandom})) >>> 20;
         default: return rgip_pkg::word_type'($signed({$urandom, $urandom})) >>> 29;
      endcase
   endfunction

   function automatic rgip_pkg::word_type rand_coef(input int idx);
      rgip_pkg::word_type x;
      x = rand_word();
      if ((idx >= 161 && idx[0]) && x == 0 && $urandom_range(0, 3) != 0) x = ONE;
      return x;
   endfunction

   task automatic initial_table();
      point_res_type none;
      none = '{0, 0, 0, 1'b0};
      for (int i = 0; i < MEM_WORDS; i++) begin
         rgip_pkg::word_type x;
         if (i < 160) x = (i % 20 == 0) ? ONE : ((i % 40 < 20) ? ONE >>> (i % 20) : 0);
         else x = i[0] ? ONE : 0;
         send_cmd(mk(rgip_pkg::OP_LOAD, i, x, 0, 0, 0), 1'b0, none);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result a=%h b=%h c=%h status=%b", $time,
                     rsp_bus.result_a, rsp_bus.result_b, rsp_bus.result_c, rsp_bus.status);
            errors++;
         end else begin
            point_res_type e;
            e = pending_q.pop_front();
            if (rsp_bus.result_a !== e.a || rsp_bus.result_b !== e.b ||
                rsp_bus.result_c !== e.c || rsp_bus.status !== e.status) begin
               $display("%0t: mismatch expected a=%h b=%h c=%h status=%b", $time,
                        e.a, e.b, e.c, e.status);
               $display("%0t:          actual   a=%h b=%h c=%h status=%b", $time,
                        rsp_bus.result_a, rsp_bus.result_b, rsp_bus.result_c,
                        rsp_bus.status);
               errors++;
            end
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   initial begin
      #100ms;
      $display("Verification failed");
      $finish;
   end

   initial begin
      plan_row_type plan [$];
      point_res_type err, none;
      point_cmd_type k;
      int dice;
      err = '{0, 0, 0, 1'b1};
      none = '{0, 0, 0, 1'b0};
      req_bus.valid = 1'b0;
      req_bus.operation = rgip_pkg::OP_LOAD;
      req_bus.table_index = '0;
      req_bus.table_value = '0;
      req_bus.coord_a = '0;
      req_bus.coord_b = '0;
      req_bus.coord_c = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      initial_table();

      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, HGT_SC, 0, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_DIRECT, 0, 0, ONE, ONE, ONE), 1'b1, err});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_INVERSE, 0, 0, ONE, ONE, ONE), 1'b1, err});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, HGT_SC, ONE, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, 20, 0, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_DIRECT, 0, 0, 0, 0, 0), 1'b1, err});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, 20, ONE, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, 140, 0, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_INVERSE, 0, 0, 0, 0, 0), 1'b1, err});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, 140, ONE, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, 200, 0, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(),
                  '{mk(rgip_pkg::OP_LOAD, 255, rgip_pkg::WORD_MIN, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, 170, -1, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_NONE, 255, -1, -1, -1, -1), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_DIRECT, 0, 0, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_DIRECT, 0, 0, rgip_pkg::WORD_MIN,
                                    rgip_pkg::WORD_MAX, -1), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_INVERSE, 0, 0, rgip_pkg::WORD_MAX,
                                    rgip_pkg::WORD_MIN, rgip_pkg::WORD_MIN), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, LAT_SC, 0, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(),
                  '{mk(rgip_pkg::OP_DIRECT, 0, 0, 3 * ONE, -ONE, ONE), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_INVERSE, 0, 0, ONE, ONE, ONE), 1'b1, err});
      plan.insert(plan.size(),
                  '{mk(rgip_pkg::OP_LOAD, LAT_SC, rgip_pkg::WORD_MAX, 0, 0, 0), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_INVERSE, 0, 0, -ONE, 2 * ONE,
                                    rgip_pkg::WORD_MAX), 1'b0, none});
      plan.insert(plan.size(), '{mk(rgip_pkg::OP_LOAD, LAT_SC, ONE, 0, 0, 0), 1'b0, none});
      foreach (plan[i]) send_cmd(plan[i].cmd, plan[i].typed, plan[i].res);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) hold_off = 1'b1;
         if (n == RANDOM_ITEMS - 150) quiet = 1'b1;
         dice = $urandom_range(0, 99);
         if (dice < 50) begin
            int idx;
            idx = $urandom_range(0, MEM_WORDS - 1);
            k = mk(rgip_pkg::OP_LOAD, idx, rand_coef(idx), rand_word(), rand_word(),
                   rand_word());
         end else if (dice < 54) begin
            k = mk(rgip_pkg::OP_LOAD, $urandom_range(MEM_WORDS, 255), {$urandom, $urandom},
                   0, 0, 0);
         end else if (dice < 57) begin
            k = mk(rgip_pkg::OP_NONE, $urandom_range(0, 255), {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
         end else begin
            k = mk(dice[0] ? rgip_pkg::OP_DIRECT : rgip_pkg::OP_INVERSE,
                   $urandom_range(0, 255), {$urandom, $urandom}, rand_word(), rand_word(),
                   rand_word());
         end
         send_cmd(k, 1'b0, none);
      end
      req_bus.valid <= 1'b0;

      while (pending_q.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
